>>> sv/utd_pkg.sv
`default_nettype none
package utd_pkg;

    localparam int unsigned T_W = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } t_state;

    localparam logic [T_W-1:0] SEC_PER_MIN       = 31'd60;
    localparam logic [T_W-1:0] SEC_PER_HOUR      = 31'd3600;
    localparam logic [T_W-1:0] SEC_PER_DAY       = 31'd86400;
    localparam logic [T_W-1:0] SEC_PER_YEAR      = 31'd31536000;
    localparam logic [T_W-1:0] SEC_PER_LEAP_YEAR = 31'd31622400;

    localparam logic [T_W-1:0] SEC_MON_31 = 31'd2678400;
    localparam logic [T_W-1:0] SEC_MON_30 = 31'd2592000;
    localparam logic [T_W-1:0] SEC_MON_29 = 31'd2505600;
    localparam logic [T_W-1:0] SEC_MON_28 = 31'd2419200;

    localparam logic [7:0] YEAR_EPOCH = 8'd70;
    localparam logic [7:0] YEAR_DOS   = 8'd80;
    localparam logic [3:0] MON_LAST   = 4'd11;
    localparam logic [3:0] MON_FEB    = 4'd1;

    localparam logic [2:0] DAY_K_TOP  = 3'd4;
    localparam logic [2:0] HOUR_K_TOP = 3'd4;
    localparam logic [2:0] MIN_K_TOP  = 3'd5;

    localparam logic [15:0] DATE_CLAMP = 16'h0021;

    // length of month in seconds, month index 0..11
    function automatic logic [T_W-1:0] month_sec(input logic [3:0] idx, input logic leap);
        logic [T_W-1:0] len;
        begin
            case (idx)
                4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = SEC_MON_31;
                4'd3, 4'd5, 4'd8, 4'd10:                   len = SEC_MON_30;
                MON_FEB:                                    len = leap ? SEC_MON_29 : SEC_MON_28;
                default:                                    len = SEC_MON_31;
            endcase
            return len;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/unix_to_dos_timestamp_core.sv
// unix time to packed dos time and date words
//
// input channel: i_valid / o_stall with i_unix_seconds (signed 32 bit seconds
// since 1970-01-01 00:00:00, no time zone). a transfer happens when i_valid
// is high and o_stall is low. output channel: o_valid / i_stall with
// o_time_word and o_date_word, one result per input transfer.
//
// one subtract/compare unit is shared by a small sequencer: whole years are
// taken off one per cycle, then whole months one per cycle, then day, hour
// and minute fields come from shifted restoring compares (5, 5 and 6 steps).
// the year walk sets most of the time an item takes from transfer to result
// (one step per year, up to 2038); zero or negative times go straight to
// the done state. o_stall is high while an item is in progress.
//
// the result sits in an output register, so a new item is taken while an
// earlier result still waits on a stalled receiver; a finished item holds
// in its last state until that register frees up.
// reset (synchronous, active low) returns to idle and drops o_valid.
`default_nettype none
module unix_to_dos_timestamp_core
    import utd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_unix_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [15:0] o_time_word,
    output logic      [15:0] o_date_word
);

    t_state r_state, n_state;

    logic [T_W-1:0] r_t,    n_t;       // remaining seconds
    logic [7:0]     r_yr,   n_yr;      // year minus 1900
    logic [3:0]     r_mon,  n_mon;     // month index 0..11
    logic [2:0]     r_k,    n_k;       // bit step of restoring compares
    logic [4:0]     r_day,  n_day;     // day of month minus one
    logic [4:0]     r_hour, n_hour;
    logic [5:0]     r_min,  n_min;
    logic           r_zero, n_zero;    // time zero or negative
    logic           r_ovalid, n_ovalid;
    logic [15:0]    r_tw,   n_tw;
    logic [15:0]    r_dw,   n_dw;

    logic           w_accept;
    logic           w_out_free;
    logic           w_leap;
    logic           w_k_last;
    logic [T_W-1:0] w_oper;
    logic [T_W-1:0] w_diff;
    logic           w_ge;
    logic [4:0]     w_kbit5;
    logic [5:0]     w_kbit6;

    assign w_accept   = i_valid & ~o_stall;
    assign w_out_free = ~r_ovalid | ~i_stall;
    assign w_leap     = (r_yr[1:0] == 2'b00);
    assign w_k_last   = (r_k == 3'd0);
    assign w_kbit5    = 5'd1 << r_k;
    assign w_kbit6    = 6'd1 << r_k;

    // operand for the shared unit, picked by the sequencer state
    always_comb begin
        case (r_state)
            ST_YEAR:  w_oper = w_leap ? SEC_PER_LEAP_YEAR : SEC_PER_YEAR;
            ST_MONTH: w_oper = month_sec(r_mon, w_leap);
            ST_DAY:   w_oper = SEC_PER_DAY << r_k;
            ST_HOUR:  w_oper = SEC_PER_HOUR << r_k;
            ST_MIN:   w_oper = SEC_PER_MIN << r_k;
            default:  w_oper = '0;
        endcase
    end

    utd_sub_unit u_sub (
        .i_a    (r_t),
        .i_b    (w_oper),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_unix_seconds[31] || (i_unix_seconds == 32'd0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_YEAR;
                    end
                end
            end
            ST_YEAR: begin
                if (!w_ge) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                // december is never walked past
                if (!w_ge || (r_mon == MON_LAST)) begin
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                if (w_k_last) begin
                    n_state = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (w_k_last) begin
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                if (w_k_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_t      = r_t;
        n_yr     = r_yr;
        n_mon    = r_mon;
        n_k      = r_k;
        n_day    = r_day;
        n_hour   = r_hour;
        n_min    = r_min;
        n_zero   = r_zero;
        n_ovalid = r_ovalid;
        n_tw     = r_tw;
        n_dw     = r_dw;
        o_stall  = (r_state != ST_IDLE);

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_t    = i_unix_seconds[T_W-1:0];
                    n_zero = i_unix_seconds[31] || (i_unix_seconds == 32'd0);
                    n_yr   = YEAR_EPOCH;
                    n_mon  = '0;
                    n_day  = '0;
                    n_hour = '0;
                    n_min  = '0;
                end
            end
            ST_YEAR: begin
                if (w_ge) begin
                    n_t  = w_diff;
                    n_yr = r_yr + 8'd1;
                end
            end
            ST_MONTH: begin
                if (w_ge && (r_mon != MON_LAST)) begin
                    n_t   = w_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_k = DAY_K_TOP;
                end
            end
            ST_DAY: begin
                if (w_ge) begin
                    n_t   = w_diff;
                    n_day = r_day | w_kbit5;
                end
                n_k = w_k_last ? HOUR_K_TOP : r_k - 3'd1;
            end
            ST_HOUR: begin
                if (w_ge) begin
                    n_t    = w_diff;
                    n_hour = r_hour | w_kbit5;
                end
                n_k = w_k_last ? MIN_K_TOP : r_k - 3'd1;
            end
            ST_MIN: begin
                if (w_ge) begin
                    n_t   = w_diff;
                    n_min = r_min | w_kbit6;
                end
                if (!w_k_last) begin
                    n_k = r_k - 3'd1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    if (r_zero) begin
                        n_tw = '0;
                        n_dw = '0;
                    end else if (r_yr < YEAR_DOS) begin
                        // positive time before 1980 clamps to 1980-01-01
                        n_tw = '0;
                        n_dw = DATE_CLAMP;
                    end else begin
                        // remaining seconds are below one minute here
                        n_tw = {r_hour, r_min, r_t[5:1]};
                        n_dw = {7'(r_yr - YEAR_DOS), r_mon + 4'd1, r_day + 5'd1};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_yr   <= n_yr;
        r_mon  <= n_mon;
        r_k    <= n_k;
        r_day  <= n_day;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_zero <= n_zero;
        r_tw   <= n_tw;
        r_dw   <= n_dw;
    end

    assign o_valid     = r_ovalid;
    assign o_time_word = r_tw;
    assign o_date_word = r_dw;

endmodule
`default_nettype wire

>>> sv/utd_sub_unit.sv
`default_nettype none
module utd_sub_unit
    import utd_pkg::*;
(
    input  wire logic [T_W-1:0] i_a,
    input  wire logic [T_W-1:0] i_b,
    output logic      [T_W-1:0] o_diff,
    output logic                o_ge
);

    logic [T_W:0] w_full;

    // one wide subtract, borrow doubles as the compare
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[T_W-1:0];
    assign o_ge   = ~w_full[T_W];

endmodule
`default_nettype wire
